@@ design/rrts_pkg.sv @@
// shared types and codes for the round-robin thread scheduler
`default_nettype none

package rrts_pkg;

  localparam int CMD_W = 3;
  localparam int ID_W  = 4;
  localparam int CNT_OUT_W = 5;

  // table depth, tied to the thread id and ready count port widths
  localparam int MAX_THREADS = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_JOIN   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BLOCK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_EXIT   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SCHED  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd6;

  // thread lifecycle codes
  localparam logic [2:0] ST_NEW        = 3'd0;
  localparam logic [2:0] ST_READY      = 3'd1;
  localparam logic [2:0] ST_RUNNING    = 3'd2;
  localparam logic [2:0] ST_BLOCKED    = 3'd3;
  localparam logic [2:0] ST_TERMINATED = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic pop;
    logic resp;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sched_pop;
  } ctl_stat_t;

endpackage

`default_nettype wire

@@ design/rrts_ctrl.sv @@
// controller state machine for the thread scheduler
`default_nettype none

module rrts_ctrl import rrts_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire ctl_stat_t stat,
  output ctl_cmd_t       cmd,
  output logic           busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = stat.sched_pop ? S_POP : S_RESP;
      end
      S_POP:  state_next = S_RESP;
      S_RESP: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy     = (state != S_IDLE);
  assign cmd.load = start && (state == S_IDLE);
  assign cmd.exec = (state == S_EXEC);
  assign cmd.pop  = (state == S_POP);
  assign cmd.resp = (state == S_RESP);

endmodule

`default_nettype wire

@@ design/rrts_datapath.sv @@
// scheduler datapath: ready queue, thread tables, running thread, main context
`default_nettype none

module rrts_datapath import rrts_pkg::*; #(
  parameter int CONTEXT_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire ctl_cmd_t                cmd,
  output ctl_stat_t                    stat,
  input  wire logic [CMD_W-1:0]        command,
  input  wire logic [ID_W-1:0]         thread_id,
  input  wire logic [CONTEXT_BITS-1:0] context_value,
  output logic [CONTEXT_BITS-1:0]      context_out,
  output logic [ID_W-1:0]              running_thread,
  output logic                         running_valid,
  output logic                         all_idle,
  output logic [CNT_OUT_W-1:0]         ready_count,
  output logic                         queue_overflow
);

  localparam int IDX_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int CNT_W = $clog2(MAX_THREADS + 1);
  localparam int SUM_W = CNT_W + 1;

  // latched command
  logic [CMD_W-1:0]        cmd_q;
  logic [ID_W-1:0]         id_q;
  logic [CONTEXT_BITS-1:0] ctx_q;

  // queue and thread state
  logic [IDX_W-1:0]        fifo_head;
  logic [CNT_W-1:0]        fifo_count;
  logic [2:0]              thread_status [MAX_THREADS];
  logic [IDX_W-1:0]        running_id;
  logic                    running_flag;
  logic [CONTEXT_BITS-1:0] main_context;
  logic                    main_context_valid;
  logic                    requeue;
  logic                    overflow;
  logic                    use_mem;
  logic [CONTEXT_BITS-1:0] ctx_out_q;

  // memories
  logic [IDX_W-1:0]        ready_fifo    [MAX_THREADS];
  logic [CONTEXT_BITS-1:0] saved_context [MAX_THREADS];
  logic [IDX_W-1:0]        fifo_rdata;
  logic [CONTEXT_BITS-1:0] ctx_rdata;

  logic                    fifo_we;
  logic [IDX_W-1:0]        fifo_waddr;
  logic [IDX_W-1:0]        fifo_wdata;
  logic                    ctx_we;
  logic [IDX_W-1:0]        ctx_waddr;

  logic                    id_ok;
  logic [IDX_W-1:0]        id_idx;
  logic [SUM_W-1:0]        tail_sum;
  logic [IDX_W-1:0]        tail;
  logic [IDX_W-1:0]        head_inc;
  logic                    queue_full;
  logic                    queue_empty;
  logic                    run_blocked;

  assign id_ok       = (32'(id_q) < 32'(MAX_THREADS));
  assign id_idx      = IDX_W'(id_q);
  assign tail_sum    = SUM_W'(fifo_head) + SUM_W'(fifo_count);
  assign tail        = (tail_sum >= SUM_W'(MAX_THREADS))
                     ? IDX_W'(tail_sum - SUM_W'(MAX_THREADS)) : IDX_W'(tail_sum);
  assign head_inc    = (fifo_head == IDX_W'(MAX_THREADS - 1)) ? '0 : fifo_head + 1'b1;
  assign queue_full  = (fifo_count >= CNT_W'(MAX_THREADS));
  assign queue_empty = (fifo_count == '0);
  assign run_blocked = (thread_status[running_id] == ST_BLOCKED);

  assign stat.sched_pop = (cmd_q == CMD_SCHED) && !queue_empty;

  // write ports
  always_comb begin
    fifo_we    = 1'b0;
    fifo_waddr = tail;
    fifo_wdata = id_idx;
    ctx_we     = 1'b0;
    ctx_waddr  = id_idx;
    if (cmd.exec) begin
      if (cmd_q == CMD_JOIN && id_ok && !queue_full) fifo_we = 1'b1;
      if (cmd_q == CMD_CREATE && id_ok) ctx_we = 1'b1;
      if (stat.sched_pop && running_flag) begin
        ctx_we    = 1'b1;
        ctx_waddr = running_id;
      end
    end else if (cmd.pop && requeue) begin
      fifo_we    = 1'b1;
      fifo_wdata = running_id;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_we) ready_fifo[fifo_waddr] <= fifo_wdata;
    fifo_rdata <= ready_fifo[fifo_head];
  end

  always_ff @(posedge clk) begin
    if (ctx_we) saved_context[ctx_waddr] <= ctx_q;
    ctx_rdata <= saved_context[fifo_rdata];
  end

  // payload latches
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= command;
      id_q  <= thread_id;
      ctx_q <= context_value;
    end
    if (cmd.exec) begin
      if (cmd_q == CMD_SCHED && queue_empty && !running_flag && main_context_valid) begin
        ctx_out_q <= main_context;
      end else begin
        ctx_out_q <= ctx_q;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_head          <= '0;
      fifo_count         <= '0;
      running_id         <= '0;
      running_flag       <= 1'b0;
      main_context       <= '0;
      main_context_valid <= 1'b0;
      requeue            <= 1'b0;
      overflow           <= 1'b0;
      use_mem            <= 1'b0;
      for (int i = 0; i < MAX_THREADS; i++) thread_status[i] <= ST_NEW;
    end else if (cmd.exec) begin
      overflow <= (cmd_q == CMD_JOIN) && id_ok && queue_full;
      use_mem  <= stat.sched_pop;
      requeue  <= 1'b0;
      case (cmd_q)
        CMD_CREATE: if (id_ok) thread_status[id_idx] <= ST_NEW;
        CMD_START:  if (id_ok) thread_status[id_idx] <= ST_READY;
        CMD_BLOCK:  if (id_ok) thread_status[id_idx] <= ST_BLOCKED;
        CMD_JOIN: begin
          if (id_ok && !queue_full) fifo_count <= fifo_count + 1'b1;
        end
        CMD_EXIT: begin
          if (running_flag) begin
            thread_status[running_id] <= ST_TERMINATED;
            running_flag              <= 1'b0;
          end
        end
        CMD_SCHED: begin
          if (!queue_empty) begin
            if (running_flag) begin
              if (!run_blocked) begin
                thread_status[running_id] <= ST_READY;
                requeue                   <= 1'b1;
              end
            end else if (!main_context_valid) begin
              main_context       <= ctx_q;
              main_context_valid <= 1'b1;
            end
            fifo_head  <= head_inc;
            fifo_count <= fifo_count - 1'b1;
          end
        end
        default: ;
      endcase
    end else if (cmd.pop) begin
      // head id arrives from the queue memory; requeue goes behind it
      if (requeue) fifo_count <= fifo_count + 1'b1;
      running_id                <= fifo_rdata;
      running_flag              <= 1'b1;
      thread_status[fifo_rdata] <= ST_RUNNING;
    end
  end

  assign context_out    = use_mem ? ctx_rdata : ctx_out_q;
  assign running_thread = running_flag ? ID_W'(running_id) : '0;
  assign running_valid  = running_flag;
  assign all_idle       = queue_empty && !running_flag;
  assign ready_count    = CNT_OUT_W'(fifo_count);
  assign queue_overflow = overflow;

endmodule

`default_nettype wire

@@ design/round_robin_thread_scheduler_top.sv @@
// top level of the round-robin thread scheduler
`default_nettype none

// Round-robin thread scheduler with a FIFO ready queue.
// command channel: a command (create, start, join, block, exit, schedule,
//   query) with thread_id and context_value transfers at a rising edge with
//   start high and busy low; busy stays high until the result is out
// result channel: done is high for exactly one cycle and carries the result
//   (context_out, running_thread, running_valid, all_idle, ready_count,
//   queue_overflow); the receiver cannot stall and must take it then
// latency: done is high in the 2nd cycle after the command transfer edge and
//   the result transfers 2 cycles after it for most commands, 3 cycles for a
//   schedule that pops the ready queue (queue read, then saved-context read,
//   both through registered memory ports)
// throughput: one command per 3 cycles, one per 4 for a popping schedule;
//   set by the two chained memory reads of a schedule and the response cycle
// reset: rst is synchronous; empties the queue, marks all threads new,
//   clears the running thread and main context, returns to idle
// queue and context tables hold undefined data until written
module round_robin_thread_scheduler_top import rrts_pkg::*; #(
  parameter int CONTEXT_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // command channel
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [CMD_W-1:0]        command,
  input  wire logic [ID_W-1:0]         thread_id,
  input  wire logic [CONTEXT_BITS-1:0] context_value,
  // result channel
  output logic                         done,
  output logic [CONTEXT_BITS-1:0]      context_out,
  output logic [ID_W-1:0]              running_thread,
  output logic                         running_valid,
  output logic                         all_idle,
  output logic [CNT_OUT_W-1:0]         ready_count,
  output logic                         queue_overflow
);

  ctl_cmd_t  ctl_cmd;
  ctl_stat_t ctl_stat;

  // sequencing: idle, execute, queue pop, response
  rrts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (ctl_stat),
    .cmd   (ctl_cmd),
    .busy  (busy)
  );

  // tables, ready queue and result fields
  rrts_datapath #(
    .CONTEXT_BITS (CONTEXT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (ctl_cmd),
    .stat           (ctl_stat),
    .command        (command),
    .thread_id      (thread_id),
    .context_value  (context_value),
    .context_out    (context_out),
    .running_thread (running_thread),
    .running_valid  (running_valid),
    .all_idle       (all_idle),
    .ready_count    (ready_count),
    .queue_overflow (queue_overflow)
  );

  // result strobe comes from the response state
  assign done = ctl_cmd.resp;

endmodule

`default_nettype wire

@@ design/rrts_checker.sv @@
// port-level checker for the thread scheduler, bound to the top level
`default_nettype none

module rrts_checker import rrts_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 done,
  input wire logic [ID_W-1:0]      running_thread,
  input wire logic                 running_valid,
  input wire logic                 all_idle,
  input wire logic [CNT_OUT_W-1:0] ready_count
);

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("not idle after reset");

  // a transfer makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy missing after command transfer");

  // a result is a single-cycle pulse that ends the command
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe longer than one cycle");

  // at a result, a set idle flag means an empty queue and no running thread
  a_idle_flag: assert property (@(posedge clk) disable iff (rst)
    done && all_idle |-> !running_valid && ready_count == '0)
    else $error("all_idle inconsistent");

  a_no_thread: assert property (@(posedge clk) disable iff (rst)
    done && !running_valid |-> running_thread == '0)
    else $error("running_thread nonzero with nothing running");

endmodule

bind round_robin_thread_scheduler_top rrts_checker u_rrts_checker (.*);

`default_nettype wire
